/* hdl/kbsp_pkg.sv */
// ----------------------------------------------------------------------------
// kbsp_pkg
// Shared types, constants and register map for the knob and button panel.
// ----------------------------------------------------------------------------
package kbsp_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [15:0] SPEED_MIN_RST  = 16'd1500;
  localparam logic [15:0] SPEED_MAX_RST  = 16'd3000;
  localparam logic [9:0]  SPEED_STEP_RST = 10'd10;
  localparam logic [15:0] TIME_MAX_RST   = 16'd28800;
  localparam logic [9:0]  TIME_STEP_RST  = 10'd60;
  localparam logic [14:0] PRESS_LIM_RST  = 15'd200;
  localparam logic [15:0] SPEED_VAL_RST  = 16'd1500;

  localparam logic [15:0] LONG_PRESS_MARK = 16'd400;
  localparam logic [15:0] COUNT_MAX       = 16'hffff;

  typedef enum logic [2:0] {
    REG_SPEED_MIN  = 3'd0,
    REG_SPEED_MAX  = 3'd1,
    REG_SPEED_STEP = 3'd2,
    REG_TIME_MAX   = 3'd3,
    REG_TIME_STEP  = 3'd4,
    REG_PRESS_LIM  = 3'd5
  } kbsp_reg_t;

  typedef enum logic [1:0] {
    KIND_LOCKOUT = 2'd0,
    KIND_EDGE    = 2'd1,
    KIND_CHECK   = 2'd2,
    KIND_SCAN    = 2'd3
  } kbsp_kind_t;

  typedef enum logic [1:0] {
    PIN_SPEED = 2'd0,
    PIN_TIME  = 2'd1,
    PIN_BTN1  = 2'd2,
    PIN_BTN2  = 2'd3
  } kbsp_pin_t;

  typedef struct packed {
    logic [15:0] speed_min;
    logic [15:0] speed_max;
    logic [9:0]  speed_step;
    logic [15:0] time_max;
    logic [9:0]  time_step;
    logic [14:0] short_press_limit;
  } kbsp_cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tick_ms;
    logic [1:0] pin;
    logic       knob_a;
    logic       knob_b;
    logic       button_one_level;
    logic       button_two_level;
  } kbsp_item_t;

  typedef struct packed {
    logic [15:0] speed_setpoint;
    logic [15:0] time_setpoint;
    logic        time_is_set;
    logic        running;
    logic        slowing_down;
    logic        start_pulse;
    logic        speed_blink_start;
    logic        time_blink_start;
  } kbsp_result_t;

  typedef struct packed {
    logic        active;
    logic [15:0] count;
    logic        toggle;
  } kbsp_btn_t;

  // one scan of a button; toggle asks for a run or stop flip
  function automatic kbsp_btn_t btn_scan(input logic active, input logic [15:0] count,
                                         input logic level, input logic [14:0] limit);
    kbsp_btn_t res;
    res.active = active;
    res.count  = count;
    res.toggle = 1'b0;
    if (active) begin
      if (!level) begin
        if (count != COUNT_MAX) begin
          res.count = count + 16'd1;
        end
      end else begin
        res.toggle = (count < {1'b0, limit});
        res.count  = '0;
        res.active = 1'b0;
      end
      if ((res.count > {1'b0, limit}) && (res.count < LONG_PRESS_MARK)) begin
        res.count = LONG_PRESS_MARK;
      end
    end
    return res;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] val, input logic [9:0] step,
                                          input logic [15:0] ceil);
    logic [16:0] sum;
    logic [15:0] v;
    sum = {1'b0, val} + {7'b0, step};
    v = sum[16] ? COUNT_MAX : sum[15:0];
    return (v > ceil) ? ceil : v;
  endfunction

  function automatic logic [15:0] sat_dec(input logic [15:0] val, input logic [9:0] step);
    return (val >= {6'b0, step}) ? (val - {6'b0, step}) : 16'd0;
  endfunction

endpackage

/* hdl/knob_button_setpoint_panel_unit.sv */
// ----------------------------------------------------------------------------
// knob_button_setpoint_panel_unit
// Front panel with two rotary knobs and two buttons driving speed and time
// setpoints and a run or stop toggle.
//
// The input channel carries one event per transaction: a lockout tick, a pin
// edge, a knob check tick or a button scan. Every input transaction yields
// exactly one output transaction with the setpoints and run flags as they
// stand after the event, plus the start and blink pulses it caused.
// The event lands in an input register; the core then updates the panel
// state and loads the output register.
// Throughput is one transaction per cycle unless the receiver stalls; a new
// event is taken while the previous result still waits in the output register.
// When the receiver stalls, the output register holds and the input register
// fills; in_stall rises only once both are occupied.
// Reset clears all state, loads the default limits, sets the speed setpoint
// to 1500 and the time setpoint to 0. The APB-style port writes the limits
// and may only be used while no transaction is in flight.
// ----------------------------------------------------------------------------
module knob_button_setpoint_panel_unit import kbsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_kind,
  input  logic [7:0]        in_tick_ms,
  input  logic [1:0]        in_pin,
  input  logic              in_knob_a,
  input  logic              in_knob_b,
  input  logic              in_button_one_level,
  input  logic              in_button_two_level,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_speed_setpoint,
  output logic [15:0]       out_time_setpoint,
  output logic              out_time_is_set,
  output logic              out_running,
  output logic              out_slowing_down,
  output logic              out_start_pulse,
  output logic              out_speed_blink_start,
  output logic              out_time_blink_start,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  kbsp_cfg_t    cfg;
  kbsp_item_t   item_r;
  logic         item_vld_r;
  kbsp_result_t res;
  kbsp_result_t res_r;
  logic         res_vld_r;
  logic         out_free;
  logic         fire;
  logic         in_take;

  assign out_free = !res_vld_r || !out_stall;
  assign fire     = item_vld_r && out_free;
  assign in_stall = item_vld_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  kbsp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kbsp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item_r),
    .cfg    (cfg),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_take) begin
      item_vld_r <= 1'b1;
    end else if (fire) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.kind             <= in_kind;
      item_r.tick_ms          <= in_tick_ms;
      item_r.pin              <= in_pin;
      item_r.knob_a           <= in_knob_a;
      item_r.knob_b           <= in_knob_b;
      item_r.button_one_level <= in_button_one_level;
      item_r.button_two_level <= in_button_two_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (out_free) begin
      res_vld_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid             = res_vld_r;
  assign out_speed_setpoint    = res_r.speed_setpoint;
  assign out_time_setpoint     = res_r.time_setpoint;
  assign out_time_is_set       = res_r.time_is_set;
  assign out_running           = res_r.running;
  assign out_slowing_down      = res_r.slowing_down;
  assign out_start_pulse       = res_r.start_pulse;
  assign out_speed_blink_start = res_r.speed_blink_start;
  assign out_time_blink_start  = res_r.time_blink_start;

endmodule

/* hdl/kbsp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// kbsp_cfg_regs
// APB-style register file holding the panel limits and step sizes.
// ----------------------------------------------------------------------------
module kbsp_cfg_regs import kbsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output kbsp_cfg_t         cfg
);

  kbsp_cfg_t cfg_r;
  logic      wr_en;
  kbsp_reg_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = kbsp_reg_t'(paddr[ADDR_W-1:2]);
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_min         <= SPEED_MIN_RST;
      cfg_r.speed_max         <= SPEED_MAX_RST;
      cfg_r.speed_step        <= SPEED_STEP_RST;
      cfg_r.time_max          <= TIME_MAX_RST;
      cfg_r.time_step         <= TIME_STEP_RST;
      cfg_r.short_press_limit <= PRESS_LIM_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SPEED_MIN:  cfg_r.speed_min         <= pwdata[15:0];
        REG_SPEED_MAX:  cfg_r.speed_max         <= pwdata[15:0];
        REG_SPEED_STEP: cfg_r.speed_step        <= pwdata[9:0];
        REG_TIME_MAX:   cfg_r.time_max          <= pwdata[15:0];
        REG_TIME_STEP:  cfg_r.time_step         <= pwdata[9:0];
        REG_PRESS_LIM:  cfg_r.short_press_limit <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SPEED_MIN:  prdata = {16'b0, cfg_r.speed_min};
      REG_SPEED_MAX:  prdata = {16'b0, cfg_r.speed_max};
      REG_SPEED_STEP: prdata = {22'b0, cfg_r.speed_step};
      REG_TIME_MAX:   prdata = {16'b0, cfg_r.time_max};
      REG_TIME_STEP:  prdata = {22'b0, cfg_r.time_step};
      REG_PRESS_LIM:  prdata = {17'b0, cfg_r.short_press_limit};
      default:        prdata = '0;
    endcase
  end

endmodule

/* hdl/kbsp_core.sv */
// ----------------------------------------------------------------------------
// kbsp_core
// Panel state registers and the single-pass update for one transaction.
// ----------------------------------------------------------------------------
module kbsp_core import kbsp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         fire,
  input  kbsp_item_t   item,
  input  kbsp_cfg_t    cfg,
  output kbsp_result_t result
);

  logic [15:0] accum_r, accum_nxt;
  logic        armed_r, armed_nxt;
  logic        spd_pend_r, spd_pend_nxt;
  logic        tim_pend_r, tim_pend_nxt;
  logic        b1_act_r, b1_act_nxt;
  logic        b2_act_r, b2_act_nxt;
  logic [15:0] b1_cnt_r, b1_cnt_nxt;
  logic [15:0] b2_cnt_r, b2_cnt_nxt;
  logic [15:0] speed_r, speed_nxt;
  logic [15:0] time_r, time_nxt;
  logic        run_r, run_nxt;
  logic        decel_r, decel_nxt;

  logic [15:0] accum_sum;
  logic [15:0] time_dec;
  kbsp_btn_t   b1, b2;
  logic        started, spd_blink, tim_blink;

  always_comb begin
    accum_nxt    = accum_r;
    armed_nxt    = armed_r;
    spd_pend_nxt = spd_pend_r;
    tim_pend_nxt = tim_pend_r;
    b1_act_nxt   = b1_act_r;
    b2_act_nxt   = b2_act_r;
    b1_cnt_nxt   = b1_cnt_r;
    b2_cnt_nxt   = b2_cnt_r;
    speed_nxt    = speed_r;
    time_nxt     = time_r;
    run_nxt      = run_r;
    decel_nxt    = decel_r;
    started      = 1'b0;
    spd_blink    = 1'b0;
    tim_blink    = 1'b0;
    accum_sum    = accum_r + {8'b0, item.tick_ms};
    time_dec     = sat_dec(time_r, cfg.time_step);
    b1 = btn_scan(b1_act_r, b1_cnt_r, item.button_one_level, cfg.short_press_limit);
    b2 = btn_scan(b2_act_r, b2_cnt_r, item.button_two_level, cfg.short_press_limit);

    case (kbsp_kind_t'(item.kind))
      KIND_LOCKOUT: begin
        accum_nxt = accum_sum;
        if (accum_sum[1:0] == 2'b00) begin
          armed_nxt = 1'b1;
          accum_nxt = '0;
        end
      end
      KIND_EDGE: begin
        if (armed_r) begin
          if (kbsp_pin_t'(item.pin) == PIN_SPEED) begin
            if (!item.knob_a && !item.knob_b) begin
              speed_nxt = sat_inc(speed_r, cfg.speed_step, cfg.speed_max);
            end else if (item.knob_a && !item.knob_b) begin
              speed_nxt = sat_dec(speed_r, cfg.speed_step);
              if (speed_nxt < cfg.speed_min) begin
                speed_nxt = cfg.speed_min;
              end
            end
            spd_pend_nxt = 1'b1;
          end else if (kbsp_pin_t'(item.pin) == PIN_TIME) begin
            if (!item.knob_a && !item.knob_b) begin
              time_nxt = sat_inc(time_r, cfg.time_step, cfg.time_max);
            end else if (item.knob_a && !item.knob_b) begin
              time_nxt = (time_dec < {6'b0, cfg.time_step}) ? 16'd0 : time_dec;
            end
            tim_pend_nxt = 1'b1;
          end
          armed_nxt = 1'b0;
        end
        if (kbsp_pin_t'(item.pin) == PIN_BTN1) begin
          b1_act_nxt = 1'b1;
        end
        if (kbsp_pin_t'(item.pin) == PIN_BTN2) begin
          b2_act_nxt = 1'b1;
        end
      end
      KIND_CHECK: begin
        spd_blink    = spd_pend_r;
        tim_blink    = tim_pend_r;
        spd_pend_nxt = 1'b0;
        tim_pend_nxt = 1'b0;
      end
      default: begin
        b1_act_nxt = b1.active;
        b1_cnt_nxt = b1.count;
        b2_act_nxt = b2.active;
        b2_cnt_nxt = b2.count;
        // button one acts before button two
        if (b1.toggle) begin
          if (!run_nxt) begin
            run_nxt      = 1'b1;
            decel_nxt    = 1'b0;
            spd_pend_nxt = 1'b0;
            tim_pend_nxt = 1'b0;
            started      = 1'b1;
          end else begin
            run_nxt   = 1'b0;
            decel_nxt = 1'b1;
          end
        end
        if (b2.toggle) begin
          if (!run_nxt) begin
            run_nxt      = 1'b1;
            decel_nxt    = 1'b0;
            spd_pend_nxt = 1'b0;
            tim_pend_nxt = 1'b0;
            started      = 1'b1;
          end else begin
            run_nxt   = 1'b0;
            decel_nxt = 1'b1;
          end
        end
      end
    endcase

    result.speed_setpoint    = speed_nxt;
    result.time_setpoint     = time_nxt;
    result.time_is_set       = (time_nxt >= {6'b0, cfg.time_step});
    result.running           = run_nxt;
    result.slowing_down      = decel_nxt;
    result.start_pulse       = started;
    result.speed_blink_start = spd_blink;
    result.time_blink_start  = tim_blink;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r    <= '0;
      armed_r    <= 1'b0;
      spd_pend_r <= 1'b0;
      tim_pend_r <= 1'b0;
      b1_act_r   <= 1'b0;
      b2_act_r   <= 1'b0;
      b1_cnt_r   <= '0;
      b2_cnt_r   <= '0;
      speed_r    <= SPEED_VAL_RST;
      time_r     <= '0;
      run_r      <= 1'b0;
      decel_r    <= 1'b0;
    end else if (fire) begin
      accum_r    <= accum_nxt;
      armed_r    <= armed_nxt;
      spd_pend_r <= spd_pend_nxt;
      tim_pend_r <= tim_pend_nxt;
      b1_act_r   <= b1_act_nxt;
      b2_act_r   <= b2_act_nxt;
      b1_cnt_r   <= b1_cnt_nxt;
      b2_cnt_r   <= b2_cnt_nxt;
      speed_r    <= speed_nxt;
      time_r     <= time_nxt;
      run_r      <= run_nxt;
      decel_r    <= decel_nxt;
    end
  end

endmodule

/* tb/knob_button_setpoint_panel_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knob_button_setpoint_panel_unit_tb
// Self-checking testbench for the knob and button front panel. A scoreboard
// class keeps its own copy of the panel state and limits, and predicts the
// result of every accepted input transaction. Results are compared field by
// field in order. A short directed sequence covers arming, knob steps, blinks
// and button presses. Six phases with different limits follow, including
// the extreme limits. Each phase mixes well-formed knob turns and button
// presses with random noise, and the first four phases idle at random on
// both channels. One phase holds a button well past the long-press mark.
// ----------------------------------------------------------------------------
module knob_button_setpoint_panel_unit_tb;
  import kbsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 80;
  localparam int NUM_PHASES = 6;
  localparam logic [15:0] HELD_MAX = 16'hffff;
  localparam logic [15:0] LONG_MARK = 16'd400;

  class panel_scoreboard;
    logic [15:0] speed_lo, speed_hi, time_hi;
    logic [9:0] speed_inc, time_inc;
    logic [14:0] press_limit;
    logic [15:0] accum, speed, secs, held_one, held_two;
    bit armed, speed_idle, time_idle, btn_one, btn_two, run, decel;
    kbsp_result_t expected_q[$];
    int errors;
    int checked;

    function new();
      speed_lo = 16'd1500;
      speed_hi = 16'd3000;
      speed_inc = 10'd10;
      time_hi = 16'd28800;
      time_inc = 10'd60;
      press_limit = 15'd200;
      accum = '0;
      speed = 16'd1500;
      secs = '0;
      held_one = '0;
      held_two = '0;
      armed = 0;
      speed_idle = 0;
      time_idle = 0;
      btn_one = 0;
      btn_two = 0;
      run = 0;
      decel = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(kbsp_reg_t idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_SPEED_MIN: speed_lo = value[15:0];
        REG_SPEED_MAX: speed_hi = value[15:0];
        REG_SPEED_STEP: speed_inc = value[9:0];
        REG_TIME_MAX: time_hi = value[15:0];
        REG_TIME_STEP: time_inc = value[9:0];
        REG_PRESS_LIM: press_limit = value[14:0];
        default: ;
      endcase
    endfunction

    function bit toggle_run();
      if (!run) begin
        run = 1;
        decel = 0;
        speed_idle = 0;
        time_idle = 0;
        return 1;
      end
      run = 0;
      decel = 1;
      return 0;
    endfunction

    function void scan_button(inout bit active, inout logic [15:0] held, input logic level,
                              inout bit started);
      if (!active) return;
      if (!level) begin
        if (held != HELD_MAX) held = held + 16'd1;
      end else begin
        if (held < {1'b0, press_limit}) started = toggle_run() | started;
        held = '0;
        active = 0;
      end
      if (held > {1'b0, press_limit} && held < LONG_MARK) held = LONG_MARK;
    endfunction

    function void add_item(kbsp_item_t it);
      kbsp_result_t want;
      int unsigned v;
      bit started, speed_blink, time_blink;
      started = 0;
      speed_blink = 0;
      time_blink = 0;
      case (it.kind)
        KIND_LOCKOUT: begin
          accum = accum + {8'd0, it.tick_ms};
          if (accum[1:0] == 2'd0) begin
            armed = 1;
            accum = '0;
          end
        end
        KIND_EDGE: begin
          if (armed) begin
            if (it.pin == PIN_SPEED) begin
              if (!it.knob_a && !it.knob_b) begin
                v = 32'(speed) + 32'(speed_inc);
                if (v > 32'(HELD_MAX)) v = 32'(HELD_MAX);
                if (v > 32'(speed_hi)) v = 32'(speed_hi);
                speed = v[15:0];
              end else if (it.knob_a && !it.knob_b) begin
                v = (speed >= {6'd0, speed_inc}) ? 32'(speed - {6'd0, speed_inc}) : 0;
                if (v < 32'(speed_lo)) v = 32'(speed_lo);
                speed = v[15:0];
              end
              speed_idle = 1;
            end else if (it.pin == PIN_TIME) begin
              if (!it.knob_a && !it.knob_b) begin
                v = 32'(secs) + 32'(time_inc);
                if (v > 32'(HELD_MAX)) v = 32'(HELD_MAX);
                if (v > 32'(time_hi)) v = 32'(time_hi);
                secs = v[15:0];
              end else if (it.knob_a && !it.knob_b) begin
                v = (secs >= {6'd0, time_inc}) ? 32'(secs - {6'd0, time_inc}) : 0;
                if (v < 32'(time_inc)) v = 0;
                secs = v[15:0];
              end
              time_idle = 1;
            end
            armed = 0;
          end
          if (it.pin == PIN_BTN1) btn_one = 1;
          if (it.pin == PIN_BTN2) btn_two = 1;
        end
        KIND_CHECK: begin
          speed_blink = speed_idle;
          time_blink = time_idle;
          speed_idle = 0;
          time_idle = 0;
        end
        default: begin
          scan_button(btn_one, held_one, it.button_one_level, started);
          scan_button(btn_two, held_two, it.button_two_level, started);
        end
      endcase
      want.speed_setpoint = speed;
      want.time_setpoint = secs;
      want.time_is_set = (secs >= {6'd0, time_inc});
      want.running = run;
      want.slowing_down = decel;
      want.start_pulse = started;
      want.speed_blink_start = speed_blink;
      want.time_blink_start = time_blink;
      expected_q.push_back(want);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("mismatch: %s", msg);
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("transaction %0d %s: got %0d expected %0d", checked, name, got, want));
    endtask

    task check_result(kbsp_result_t got);
      kbsp_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("transaction %0d arrived with nothing expected", checked));
        return;
      end
      want = expected_q.pop_front();
      check_field("speed_setpoint", got.speed_setpoint, want.speed_setpoint);
      check_field("time_setpoint", got.time_setpoint, want.time_setpoint);
      check_field("time_is_set", 16'(got.time_is_set), 16'(want.time_is_set));
      check_field("running", 16'(got.running), 16'(want.running));
      check_field("slowing_down", 16'(got.slowing_down), 16'(want.slowing_down));
      check_field("start_pulse", 16'(got.start_pulse), 16'(want.start_pulse));
      check_field("speed_blink_start", 16'(got.speed_blink_start),
                  16'(want.speed_blink_start));
      check_field("time_blink_start", 16'(got.time_blink_start),
                  16'(want.time_blink_start));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_kind;
  logic [7:0] in_tick_ms;
  logic [1:0] in_pin;
  logic in_knob_a, in_knob_b, in_button_one_level, in_button_two_level;
  logic out_valid, out_stall;
  logic [15:0] out_speed_setpoint, out_time_setpoint;
  logic out_time_is_set, out_running, out_slowing_down, out_start_pulse;
  logic out_speed_blink_start, out_time_blink_start;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  panel_scoreboard sb;
  kbsp_result_t got_r;
  int snd_idle, rcv_idle, up_pct, knob_pct, phase_items;
  int sent, idle_cycles, hold_left;
  int unsigned smin;
  bit hold_req, paused;

  knob_button_setpoint_panel_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_tick_ms(in_tick_ms),
    .in_pin(in_pin),
    .in_knob_a(in_knob_a),
    .in_knob_b(in_knob_b),
    .in_button_one_level(in_button_one_level),
    .in_button_two_level(in_button_two_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_speed_setpoint(out_speed_setpoint),
    .out_time_setpoint(out_time_setpoint),
    .out_time_is_set(out_time_is_set),
    .out_running(out_running),
    .out_slowing_down(out_slowing_down),
    .out_start_pulse(out_start_pulse),
    .out_speed_blink_start(out_speed_blink_start),
    .out_time_blink_start(out_time_blink_start),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic kbsp_item_t mk(kbsp_kind_t k, logic [7:0] t, kbsp_pin_t p, logic a,
                                    logic b, logic l1, logic l2);
    kbsp_item_t it;
    it.kind = k;
    it.tick_ms = t;
    it.pin = p;
    it.knob_a = a;
    it.knob_b = b;
    it.button_one_level = l1;
    it.button_two_level = l2;
    return it;
  endfunction

  function automatic kbsp_item_t rand_item();
    return kbsp_item_t'(16'($urandom));
  endfunction

  task automatic send_item(kbsp_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= it.kind;
    in_tick_ms <= it.tick_ms;
    in_pin <= it.pin;
    in_knob_a <= it.knob_a;
    in_knob_b <= it.knob_b;
    in_button_one_level <= it.button_one_level;
    in_button_two_level <= it.button_two_level;
    do @(posedge clk); while (in_stall);
    sb.add_item(it);
    sent++;
  endtask

  task automatic rest_sender();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    rest_sender();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic apb_write(kbsp_reg_t idx, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
  endtask

  task automatic set_config(int unsigned smn, int unsigned smx, int unsigned sstep,
                            int unsigned tmx, int unsigned tstep, int unsigned lim);
    drain();
    repeat (4) @(posedge clk);
    apb_write(REG_SPEED_MIN, smn);
    apb_write(REG_SPEED_MAX, smx);
    apb_write(REG_SPEED_STEP, sstep);
    apb_write(REG_TIME_MAX, tmx);
    apb_write(REG_TIME_STEP, tstep);
    apb_write(REG_PRESS_LIM, lim);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic knob_turn();
    kbsp_item_t it;
    it = rand_item();
    it.kind = KIND_LOCKOUT;
    // top up the accumulator to a multiple of four so the knobs arm
    if ($urandom_range(4) != 0) it.tick_ms = 8'(4 - sb.accum[1:0] + 4 * $urandom_range(60));
    send_item(it);
    it = rand_item();
    it.kind = KIND_EDGE;
    it.pin = $urandom_range(1) ? PIN_TIME : PIN_SPEED;
    if ($urandom_range(7) != 0) begin
      it.knob_b = 1'b0;
      it.knob_a = ($urandom_range(99) >= up_pct);
    end
    send_item(it);
    if ($urandom_range(7) == 0) begin
      it = rand_item();
      it.kind = KIND_EDGE;
      send_item(it);
    end
  endtask

  task automatic button_press();
    kbsp_item_t it;
    int unsigned hold, lim;
    bit two, long_press;
    two = 1'($urandom_range(1));
    lim = 32'(sb.press_limit);
    long_press = (lim <= 30) ? ($urandom_range(3) == 0) : ($urandom_range(15) == 0);
    if (long_press && lim <= 300) hold = lim + $urandom_range(3);
    else hold = $urandom_range(lim > 30 ? 30 : lim - 1);
    it = rand_item();
    it.kind = KIND_EDGE;
    it.pin = two ? PIN_BTN2 : PIN_BTN1;
    send_item(it);
    repeat (hold) begin
      it = rand_item();
      it.kind = KIND_SCAN;
      if (two) it.button_two_level = 1'b0;
      else it.button_one_level = 1'b0;
      send_item(it);
    end
    it = rand_item();
    it.kind = KIND_SCAN;
    if (two) it.button_two_level = 1'b1;
    else it.button_one_level = 1'b1;
    send_item(it);
  endtask

  task automatic both_buttons();
    int unsigned hold;
    hold = $urandom_range(sb.press_limit > 40 ? 40 : sb.press_limit);
    send_item(mk(KIND_EDGE, 8'($urandom), PIN_BTN1, 1'($urandom), 1'($urandom),
                 1'($urandom), 1'($urandom)));
    send_item(mk(KIND_EDGE, 8'($urandom), PIN_BTN2, 1'($urandom), 1'($urandom),
                 1'($urandom), 1'($urandom)));
    repeat (hold)
      send_item(mk(KIND_SCAN, 8'($urandom), PIN_SPEED, 1'($urandom), 1'($urandom),
                   1'b0, 1'b0));
    send_item(mk(KIND_SCAN, 8'($urandom), PIN_TIME, 1'($urandom), 1'($urandom), 1'b1, 1'b1));
  endtask

  task automatic random_sequence();
    kbsp_item_t it;
    if ($urandom_range(99) < knob_pct) begin
      knob_turn();
    end else begin
      case ($urandom_range(6))
        0: begin
          it = rand_item();
          it.kind = KIND_CHECK;
          send_item(it);
        end
        1, 2, 3: button_press();
        4: both_buttons();
        default: send_item(rand_item());
      endcase
    end
  endtask

  task automatic wrap_accum();
    // keep the sum at one modulo four until it wraps, then arm
    send_item(mk(KIND_LOCKOUT, 8'(4 - sb.accum[1:0]), PIN_SPEED, 0, 0, 1, 1));
    send_item(mk(KIND_LOCKOUT, 8'd1, PIN_TIME, 1, 1, 0, 0));
    repeat (261) send_item(mk(KIND_LOCKOUT, 8'd252, PIN_BTN1, 1'($urandom), 1'($urandom),
                              1, 1));
    send_item(mk(KIND_LOCKOUT, 8'd3, PIN_BTN2, 0, 1, 1, 0));
  endtask

  task automatic hold_button_long();
    kbsp_item_t it;
    it = rand_item();
    it.kind = KIND_EDGE;
    it.pin = PIN_BTN1;
    send_item(it);
    repeat (LONG_HOLD) begin
      it = rand_item();
      it.kind = KIND_SCAN;
      it.button_one_level = 1'b0;
      send_item(it);
    end
    it = rand_item();
    it.kind = KIND_SCAN;
    it.button_one_level = 1'b1;
    send_item(it);
  endtask

  task automatic directed();
    send_item(mk(KIND_CHECK, 8'd0, PIN_SPEED, 0, 0, 1, 1));
    send_item(mk(KIND_EDGE, 8'hff, PIN_SPEED, 0, 0, 1, 1));
    send_item(mk(KIND_LOCKOUT, 8'd4, PIN_SPEED, 0, 0, 1, 1));
    send_item(mk(KIND_EDGE, 8'd0, PIN_SPEED, 0, 0, 1, 1));
    send_item(mk(KIND_LOCKOUT, 8'd255, PIN_BTN2, 1, 1, 0, 0));
    send_item(mk(KIND_LOCKOUT, 8'd1, PIN_SPEED, 0, 0, 1, 1));
    send_item(mk(KIND_EDGE, 8'd0, PIN_TIME, 0, 0, 1, 1));
    send_item(mk(KIND_LOCKOUT, 8'd0, PIN_SPEED, 0, 0, 1, 1));
    send_item(mk(KIND_EDGE, 8'd0, PIN_TIME, 1, 0, 1, 1));
    send_item(mk(KIND_LOCKOUT, 8'd8, PIN_SPEED, 0, 0, 1, 1));
    send_item(mk(KIND_EDGE, 8'd0, PIN_SPEED, 1, 0, 1, 1));
    send_item(mk(KIND_LOCKOUT, 8'd4, PIN_SPEED, 0, 0, 1, 1));
    send_item(mk(KIND_EDGE, 8'd0, PIN_SPEED, 0, 1, 1, 1));
    send_item(mk(KIND_LOCKOUT, 8'd4, PIN_SPEED, 0, 0, 1, 1));
    send_item(mk(KIND_EDGE, 8'd0, PIN_TIME, 1, 1, 1, 1));
    send_item(mk(KIND_CHECK, 8'd0, PIN_SPEED, 0, 0, 1, 1));
    send_item(mk(KIND_EDGE, 8'd0, PIN_BTN1, 0, 0, 1, 1));
    send_item(mk(KIND_SCAN, 8'd0, PIN_SPEED, 0, 0, 0, 0));
    send_item(mk(KIND_SCAN, 8'd0, PIN_SPEED, 0, 0, 0, 1));
    send_item(mk(KIND_SCAN, 8'd0, PIN_SPEED, 0, 0, 1, 1));
    send_item(mk(KIND_LOCKOUT, 8'd4, PIN_SPEED, 0, 0, 1, 1));
    send_item(mk(KIND_EDGE, 8'd0, PIN_BTN2, 0, 0, 1, 1));
    send_item(mk(KIND_SCAN, 8'd0, PIN_SPEED, 0, 0, 1, 1));
    send_item(mk(KIND_EDGE, 8'd0, PIN_BTN1, 0, 0, 1, 1));
    send_item(mk(KIND_EDGE, 8'd0, PIN_BTN2, 0, 0, 1, 1));
    send_item(mk(KIND_SCAN, 8'd0, PIN_SPEED, 0, 0, 1, 1));
  endtask

  // receiver: random stall, one long hold on request, check each transaction
  always begin
    @(negedge clk);
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
    @(posedge clk);
    if (rst_n && out_valid && !out_stall) begin
      got_r.speed_setpoint = out_speed_setpoint;
      got_r.time_setpoint = out_time_setpoint;
      got_r.time_is_set = out_time_is_set;
      got_r.running = out_running;
      got_r.slowing_down = out_slowing_down;
      got_r.start_pulse = out_start_pulse;
      got_r.speed_blink_start = out_speed_blink_start;
      got_r.time_blink_start = out_time_blink_start;
      sb.check_result(got_r);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = '0;
    in_tick_ms = '0;
    in_pin = '0;
    in_knob_a = 1'b0;
    in_knob_b = 1'b0;
    in_button_one_level = 1'b1;
    in_button_two_level = 1'b1;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_cycles = 0;
    hold_left = 0;
    hold_req = 1'b0;
    snd_idle = 28;
    rcv_idle = 86;
    up_pct = 50;
    knob_pct = 35;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_config(1500, 3000, 10, 28800, 60, 200);
    directed();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: set_config(0, 65535, 1023, 65535, 1023, 1);
        1: set_config(65535, 0, 1, 0, 1, 32767);
        4: set_config(1500, 3000, 10, 28800, 60, 200);
        default: begin
          smin = $urandom_range(4000);
          set_config(smin, smin + $urandom_range(4000), $urandom_range(1023, 1),
                     $urandom_range(9000), $urandom_range(1023, 1), $urandom_range(30, 1));
        end
      endcase
      if (ph < 2) begin
        snd_idle = 28;
        rcv_idle = 86;
      end else if (ph < 4) begin
        snd_idle = 86;
        rcv_idle = 28;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      knob_pct = (ph == 0) ? 85 : 35;
      up_pct = (ph == 0) ? 95 : (ph == 3) ? 25 : 55;
      phase_items = (ph == 0) ? 250 : 230;
      if (ph == 1) hold_req = 1'b1;
      if (ph == 2) wrap_accum();
      sent = 0;
      paused = 1'b0;
      while (sent < phase_items) begin
        random_sequence();
        if (!paused && sent >= phase_items / 2) begin
          drain();
          paused = 1'b1;
        end
      end
      if (ph == NUM_PHASES - 1) hold_button_long();
    end
    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* knob_button_setpoint_panel_unit.f */
hdl/kbsp_pkg.sv
hdl/kbsp_cfg_regs.sv
hdl/kbsp_core.sv
hdl/knob_button_setpoint_panel_unit.sv
tb/knob_button_setpoint_panel_unit_tb.sv
